@@ design/lftd_pkg.sv @@
// Package: format codes and the stage-to-stage word types of the converter.
`default_nettype none
package lftd_pkg;

	typedef enum logic [3:0] {
		FMT_1750A32 = 4'd0,
		FMT_1750A48 = 4'd1,
		FMT_TI32    = 4'd2,
		FMT_TI40    = 4'd3,
		FMT_HEX32   = 4'd4,
		FMT_HEX64   = 4'd5,
		FMT_VAXF    = 4'd6,
		FMT_VAXD    = 4'd7,
		FMT_VAXG    = 4'd8
	} fmt_t;

	localparam int ExpW = 13;

	// sign, magnitude and power of two of one decoded word
	typedef struct packed {
		logic                   zero;
		logic                   neg;
		logic [63:0]            mag;
		logic signed [ExpW-1:0] exp2;
	} triple_t;

	// normalized form: mag has its top one at bit 63
	typedef struct packed {
		logic                   zero;
		logic                   neg;
		logic [63:0]            mag;
		logic signed [ExpW-1:0] lead;
	} norm_t;

endpackage
`default_nettype wire

@@ design/lftd_decode.sv @@
// Decode stage: source word and format code to sign, magnitude and exponent.
`default_nettype none
module lftd_decode (
	input  wire logic [3:0]       op,
	input  wire logic [63:0]      raw_word,
	output lftd_pkg::triple_t     trip
);
	import lftd_pkg::*;

	logic [31:0] w32;
	logic [23:0] m24;
	logic [39:0] m40;
	logic [7:0]  e8;
	logic [6:0]  e7;
	logic [10:0] e11;

	always_comb begin
		w32 = raw_word[31:0];
		m24 = '0;
		m40 = '0;
		e8 = '0;
		e7 = '0;
		e11 = '0;
		trip = '0;
		case (op)
			FMT_1750A32: begin
				m24 = w32[31:8];
				e8 = w32[7:0];
				trip.neg = m24[23];
				trip.mag = m24[23] ? {40'd0, 24'd0 - m24} : {40'd0, m24};
				trip.exp2 = ExpW'($signed(e8)) - ExpW'(23);
			end
			FMT_1750A48: begin
				m40 = {raw_word[47:24], raw_word[15:0]};
				e8 = raw_word[23:16];
				trip.neg = m40[39];
				trip.mag = m40[39] ? {24'd0, 40'd0 - m40} : {24'd0, m40};
				trip.exp2 = ExpW'($signed(e8)) - ExpW'(39);
			end
			FMT_TI32: begin
				e8 = w32[31:24];
				trip.zero = (e8 == 8'h80);
				trip.neg = w32[23];
				trip.mag = w32[23] ? (64'd1 << 24) - {41'd0, w32[22:0]}
					: (64'd1 << 23) + {41'd0, w32[22:0]};
				trip.exp2 = ExpW'($signed(e8)) - ExpW'(23);
			end
			FMT_TI40: begin
				e8 = raw_word[39:32];
				trip.zero = (e8 == 8'h80);
				trip.neg = raw_word[31];
				trip.mag = raw_word[31] ? (64'd1 << 32) - {33'd0, raw_word[30:0]}
					: (64'd1 << 31) + {33'd0, raw_word[30:0]};
				trip.exp2 = ExpW'($signed(e8)) - ExpW'(31);
			end
			FMT_HEX32: begin
				e7 = w32[30:24];
				trip.neg = w32[31];
				trip.mag = {40'd0, w32[23:0]};
				trip.exp2 = ExpW'({e7, 2'b00}) - ExpW'(256 + 24);
			end
			FMT_HEX64: begin
				e7 = raw_word[62:56];
				trip.neg = raw_word[63];
				trip.mag = {8'd0, raw_word[55:0]};
				trip.exp2 = ExpW'({e7, 2'b00}) - ExpW'(256 + 56);
			end
			FMT_VAXF: begin
				e8 = w32[30:23];
				trip.neg = w32[31];
				trip.mag = {40'd0, 1'b1, w32[22:0]};
				trip.exp2 = ExpW'(e8) - ExpW'(128 + 24);
			end
			FMT_VAXD: begin
				e8 = raw_word[62:55];
				trip.neg = raw_word[63];
				trip.mag = {8'd0, 1'b1, raw_word[54:0]};
				trip.exp2 = ExpW'(e8) - ExpW'(128 + 56);
			end
			FMT_VAXG: begin
				e11 = raw_word[62:52];
				trip.neg = raw_word[63];
				trip.mag = {11'd0, 1'b1, raw_word[51:0]};
				trip.exp2 = ExpW'(e11) - ExpW'(1024 + 53);
			end
			default: begin
				trip = '0;
			end
		endcase
		if (trip.mag == '0) begin
			trip.zero = 1'b1;
		end
		// zero results are +0 except base-16, which keeps its sign
		if (trip.zero && !(op == FMT_HEX32 || op == FMT_HEX64)) begin
			trip.neg = 1'b0;
		end
	end

endmodule
`default_nettype wire

@@ design/lftd_norm.sv @@
// Normalize stage: leading-one count and left shift of the magnitude.
`default_nettype none
module lftd_norm (
	input  wire lftd_pkg::triple_t trip,
	output lftd_pkg::norm_t        nrm
);
	import lftd_pkg::*;

	logic [5:0]  lz;
	logic [63:0] m;

	always_comb begin
		m = trip.mag;
		lz = '0;
		if (m[63:32] == '0) begin lz[5] = 1'b1; m = m << 32; end
		if (m[63:48] == '0) begin lz[4] = 1'b1; m = m << 16; end
		if (m[63:56] == '0) begin lz[3] = 1'b1; m = m << 8; end
		if (m[63:60] == '0) begin lz[2] = 1'b1; m = m << 4; end
		if (m[63:62] == '0) begin lz[1] = 1'b1; m = m << 2; end
		if (!m[63]) begin lz[0] = 1'b1; m = m << 1; end
		nrm.zero = trip.zero;
		nrm.neg = trip.neg;
		nrm.mag = m;
		// value = m * 2^(lead - 63)
		nrm.lead = trip.exp2 + ExpW'(63) - ExpW'(lz);
	end

endmodule
`default_nettype wire

@@ design/lftd_round.sv @@
// Round stage: denormal shift, nearest-even rounding and binary64 packing.
`default_nettype none
module lftd_round (
	input  wire lftd_pkg::norm_t nrm,
	output logic [63:0]          bits
);
	import lftd_pkg::*;

	logic signed [ExpW-1:0] sh;
	logic [6:0]  sh7;
	logic [64:0] wide;
	logic [52:0] q;
	logic        grd;
	logic        stk;
	logic        up;
	logic [63:0] sum;
	logic [ExpW-1:0] bexp;

	always_comb begin
		// extra right shift below normal range: lead < -1022
		sh = ExpW'(-1022) - nrm.lead;
		if (sh < 0) begin
			sh = '0;
		end
		sh7 = (sh > ExpW'(64)) ? 7'd64 : sh[6:0];
		wide = {nrm.mag, 1'b0} >> sh7;
		q = wide[64:12];
		grd = wide[11];
		stk = (wide[10:0] != '0) || ((({nrm.mag, 1'b0} << (7'd65 - sh7)) != '0)
			&& sh7 != 7'd0);
		up = grd && (stk || q[0]);
		bexp = (sh == '0) ? ExpW'(nrm.lead + ExpW'(1022)) : '0;
		sum = {bexp[10:0], 52'd0} + {11'd0, q} + {63'd0, up};
		if (nrm.zero) begin
			bits = {nrm.neg, 63'd0};
		end else if (!nrm.lead[ExpW-1] && nrm.lead > ExpW'(1023)) begin
			bits = {nrm.neg, 11'h7FF, 52'd0};
		end else begin
			bits = {nrm.neg, sum[62:0]};
		end
	end

endmodule
`default_nettype wire

@@ design/legacy_float_to_double.sv @@
// Top level: three-stage legacy float word to binary64 converter.
//   channel  valid      ready      payload
//   in       in_valid   in_ready   op, raw_word
//   out      out_valid  out_ready  double_bits
// One word per cycle while the output is not stalled; stages in order: decode, normalize, round.
// Reset clears the stage valid bits only.
// A stage advances when its next stage is empty or moving; a stall holds a full pipe.
`default_nettype none
module legacy_float_to_double (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [3:0]  op,
	input  wire logic [63:0] raw_word,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic [63:0]      double_bits
);
	import lftd_pkg::*;

	triple_t     trip_c, trip_s1;
	norm_t       nrm_c, nrm_s2;
	logic [63:0] bits_c, bits_s3;
	logic        v_s1, v_s2, v_s3;
	logic        adv1, adv2, adv3;

	lftd_decode u_dec (.op(op), .raw_word(raw_word), .trip(trip_c));
	lftd_norm   u_norm (.trip(trip_s1), .nrm(nrm_c));
	lftd_round  u_rnd (.nrm(nrm_s2), .bits(bits_c));

	assign adv3 = !v_s3 || out_ready;
	assign adv2 = !v_s2 || adv3;
	assign adv1 = !v_s1 || adv2;
	assign in_ready = adv1;
	assign out_valid = v_s3;
	assign double_bits = bits_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			if (adv1) v_s1 <= in_valid;
			if (adv2) v_s2 <= v_s1;
			if (adv3) v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv1 && in_valid) trip_s1 <= trip_c;
		if (adv2 && v_s1) nrm_s2 <= nrm_c;
		if (adv3 && v_s2) bits_s3 <= bits_c;
	end

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(double_bits))
		else $error("result word changed under stall");
	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!v_s1 || !v_s2 || !v_s3 || out_ready || !in_ready)
		else $error("full pipe took a word");
	a_flow: assert property (@(posedge clk) disable iff (!arst_n)
		v_s2 && !v_s3 |=> v_s3)
		else $error("word lost between stages");

endmodule
`default_nettype wire

@@ test/lftd_checker.sv @@
// Checker: watches both channels, predicts binary64 results and compares them.
`timescale 1ns / 1ps
module lftd_checker (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	input  wire logic        in_ready,
	input  wire logic [3:0]  op,
	input  wire logic [63:0] raw_word,
	input  wire logic        out_valid,
	input  wire logic        out_ready,
	input  wire logic [63:0] double_bits,
	output int               fail_count,
	output int               pending
);
	import lftd_pkg::*;

	logic [63:0] expected_q[$];

	function automatic logic [63:0] pack_binary64(logic neg, logic [63:0] mag, int exp2);
		logic [63:0] sgn, q, rem, half, bits;
		int p, lsb, drop;
		sgn = neg ? 64'h8000_0000_0000_0000 : 64'd0;
		if (mag == 0)
			return sgn;
		p = 63;
		while (mag[p] == 1'b0)
			p--;
		lsb = p + exp2 - 52;
		if (lsb < -1074)
			lsb = -1074;
		if (lsb > 1023 - 52)
			return sgn | 64'h7FF0_0000_0000_0000;
		drop = lsb - exp2;
		if (drop <= 0) begin
			q = mag << (-drop);
		end else if (drop > 64) begin
			q = 0;
		end else begin
			if (drop == 64) begin
				q = 0;
				rem = mag;
				half = 64'h8000_0000_0000_0000;
			end else begin
				q = mag >> drop;
				rem = mag & ((64'd1 << drop) - 1);
				half = 64'd1 << (drop - 1);
			end
			if (rem > half || (rem == half && q[0]))
				q++;
		end
		bits = (64'(lsb + 1074) << 52) + q;
		if ((bits >> 52) >= 64'h7FF)
			bits = 64'h7FF0_0000_0000_0000;
		return sgn | bits;
	endfunction

	function automatic int sext8(logic [7:0] v);
		return int'($signed(v));
	endfunction

	function automatic logic [63:0] twos_value(logic [63:0] m, int width, int exp2);
		logic [63:0] top;
		top = 64'd1 << (width - 1);
		if ((m & top) != 0)
			return pack_binary64(1'b1, (top << 1) - m, exp2);
		return pack_binary64(1'b0, m, exp2);
	endfunction

	function automatic logic [63:0] dsp_value(logic [63:0] w, int fbits);
		logic [7:0] e;
		logic [63:0] f;
		e = 8'(w >> (fbits + 1));
		f = w & ((64'd1 << fbits) - 1);
		if (e == 8'h80)
			return 64'd0;
		if (w[fbits])
			return pack_binary64(1'b1, (64'd1 << (fbits + 1)) - f, sext8(e) - fbits);
		return pack_binary64(1'b0, (64'd1 << fbits) + f, sext8(e) - fbits);
	endfunction

	function automatic logic [63:0] convert_word(logic [3:0] code, logic [63:0] w);
		logic [63:0] w32, m;
		w32 = {32'd0, w[31:0]};
		case (code)
			FMT_1750A32: return twos_value(w32 >> 8, 24, sext8(w[7:0]) - 23);
			FMT_1750A48: begin
				m = ((w & 64'hFFFFFF000000) >> 8) | (w & 64'hFFFF);
				return twos_value(m, 40, sext8(w[23:16]) - 39);
			end
			FMT_TI32: return dsp_value(w32, 23);
			FMT_TI40: return dsp_value(w & 64'hFF_FFFF_FFFF, 31);
			FMT_HEX32: return pack_binary64(w[31], {40'd0, w[23:0]},
				4 * (int'(w[30:24]) - 64) - 24);
			FMT_HEX64: return pack_binary64(w[63], {8'd0, w[55:0]},
				4 * (int'(w[62:56]) - 64) - 56);
			FMT_VAXF: return pack_binary64(w[31], {40'd1, w[22:0]},
				int'(w[30:23]) - 128 - 24);
			FMT_VAXD: return pack_binary64(w[63], {8'd1, w[54:0]},
				int'(w[62:55]) - 128 - 56);
			FMT_VAXG: return pack_binary64(w[63], {11'd1, w[51:0]},
				int'(w[62:52]) - 1024 - 53);
			default: return 64'd0;
		endcase
	endfunction

	task automatic report_mismatch(string msg);
		$display("%0t mismatch: %s", $realtime, msg);
		fail_count++;
	endtask

	assign pending = expected_q.size();

	initial fail_count = 0;

	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && in_ready)
				expected_q.push_back(convert_word(op, raw_word));
			if (out_valid && out_ready) begin
				if (expected_q.size() == 0)
					report_mismatch($sformatf("unexpected word %h", double_bits));
				else if (expected_q[0] !== double_bits)
					report_mismatch($sformatf("double_bits %h, expected %h",
						double_bits, expected_q.pop_front()));
				else
					void'(expected_q.pop_front());
			end
		end
	end
endmodule

@@ test/legacy_float_to_double_tb.sv @@
// Testbench top: stimulus, idling and verdict for the legacy float converter.
`timescale 1ns / 1ps
module legacy_float_to_double_tb;
	import lftd_pkg::*;

	logic        clk = 0;
	logic        arst_n = 0;
	logic        in_valid = 0;
	logic        in_ready;
	logic [3:0]  op = 0;
	logic [63:0] raw_word = 0;
	logic        out_valid;
	logic        out_ready = 0;
	logic [63:0] double_bits;
	int          fail_count;
	int          pending;
	int          cycles = 0;

	localparam int CycleLimit = 200000;

	always begin
		#2 clk = 1;
		#2 clk = 0;
	end

	legacy_float_to_double u_top (.*);

	lftd_checker u_chk (.*);

	function automatic int gap_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 40)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(4, 30);
	endfunction

	function automatic logic [63:0] rand64();
		return {$urandom, $urandom};
	endfunction

	task automatic send_word(logic [3:0] code, logic [63:0] w);
		op <= code;
		raw_word <= w;
		in_valid <= 1;
		do @(posedge clk); while (!in_ready);
		@(negedge clk);
	endtask

	task automatic send_idle(int n);
		in_valid <= 0;
		repeat (n) @(negedge clk);
	endtask

	// random stall on the receiving side, with quiet stretches
	initial begin
		int n;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if ($urandom_range(0, 9) == 0) begin
				out_ready <= 1;
				repeat ($urandom_range(20, 80)) @(negedge clk);
			end
			n = gap_len();
			out_ready <= (n == 0);
			repeat (n) @(negedge clk);
			out_ready <= 1;
		end
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CycleLimit) begin
			$display("TEST FAILED");
			$finish;
		end
	end

	initial begin
		logic [63:0] w;
		int k;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1;
		@(negedge clk);
		// directed: extremes, each format, DSP zero exponent, unknown codes
		for (k = 0; k <= 8; k++) begin
			send_word(4'(k), 64'd0);
			send_word(4'(k), '1);
		end
		send_word(FMT_TI32, 64'h8000_0000);
		send_word(FMT_TI40, 64'h80_FFFF_FFFF);
		send_word(FMT_HEX32, 64'h8000_0000);
		send_word(FMT_HEX64, 64'h8000_0000_0000_0000);
		send_word(FMT_VAXG, 64'h0000_0000_0000_0001);
		send_word(FMT_1750A32, 64'h8000_0000);
		send_word(4'd9, rand64());
		send_word(4'd15, rand64());
		// random part
		for (k = 0; k < 1050; k++) begin
			w = rand64();
			case ($urandom_range(0, 9))
				0: w[7:0] = 8'h80;
				1: w = w >> $urandom_range(0, 63);
				2: w[62:52] = 11'(($urandom_range(0, 1)) ? $urandom_range(0, 60) : 0);
				default: ;
			endcase
			if ($urandom_range(0, 4) == 0)
				w[39:32] = 8'h80;
			send_word(($urandom_range(0, 19) == 0) ? 4'($urandom_range(9, 15))
				: 4'($urandom_range(0, 8)), w);
			if ($urandom_range(0, 2) == 0)
				send_idle(gap_len());
		end
		in_valid <= 0;
		while (pending != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
		if (fail_count == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end
endmodule

@@ filelist.f @@
design/lftd_pkg.sv
design/lftd_decode.sv
design/lftd_norm.sv
design/lftd_round.sv
design/legacy_float_to_double.sv
test/lftd_checker.sv
test/legacy_float_to_double_tb.sv
